[rtl/core/rcmc_pkg.sv]
// Package with the shared types, codes and constants of the RGB color majority classifier.
`default_nettype none

package rcmc_pkg;

    localparam int FIELD_W    = 16;
    localparam int THR_W      = 16;
    localparam int CNT_CFG_W  = 4;
    localparam int CLASS_W    = 3;
    localparam int VOTE_W     = 4;
    localparam int NUM_VOTES  = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int WIDTH_BITS_DEF  = 16;
    localparam int MAX_SAMPLES_DEF = 15;

    localparam logic [THR_W-1:0]     BLACK_THR_RST   = 16'd4500;
    localparam logic [THR_W-1:0]     WHITE_THR_RST   = 16'd425;
    localparam logic [CNT_CFG_W-1:0] RUN_LEN_RST     = 4'd5;
    localparam logic [CNT_CFG_W-1:0] VOTES_NEED_RST  = 4'd3;
    localparam logic [VOTE_W-1:0]    VOTE_MAX        = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTES_NEED  = 8'd3;

    localparam logic [CLASS_W-1:0] CLASS_NONE  = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_RED   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_GREEN = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_BLUE  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_WHITE = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_BLACK = 3'd5;

    typedef struct packed {
        logic [FIELD_W-1:0] red_width;
        logic [FIELD_W-1:0] green_width;
        logic [FIELD_W-1:0] blue_width;
    } t_in_beat;

    typedef struct packed {
        logic [CLASS_W-1:0] sample_class;
        logic               decision_ready;
        logic [CLASS_W-1:0] decided_color;
    } t_out_beat;

    typedef struct packed {
        logic               ready;
        logic [CLASS_W-1:0] color;
    } t_decision;

endpackage

`default_nettype wire

[rtl/core/rcmc_classify.sv]
// Combinational classification of one RGB pulse width sample.
`default_nettype none

module rcmc_classify #(
    parameter int CMP_W = 16
) (
    input  var rcmc_pkg::t_in_beat                i_beat,
    input  var logic [rcmc_pkg::THR_W-1:0]        i_black_thr,
    input  var logic [rcmc_pkg::THR_W-1:0]        i_white_thr,
    output var logic [rcmc_pkg::CLASS_W-1:0]      o_class
);
    import rcmc_pkg::*;

    logic [CMP_W-1:0] r_w;
    logic [CMP_W-1:0] g_w;
    logic [CMP_W-1:0] b_w;
    logic [CMP_W-1:0] bt;
    logic [CMP_W-1:0] wt;

    assign r_w = i_beat.red_width[CMP_W-1:0];
    assign g_w = i_beat.green_width[CMP_W-1:0];
    assign b_w = i_beat.blue_width[CMP_W-1:0];
    assign bt  = i_black_thr[CMP_W-1:0];
    assign wt  = i_white_thr[CMP_W-1:0];

    always_comb begin
        if (r_w > bt && g_w > bt && b_w > bt) begin
            o_class = CLASS_BLACK;
        end else if (r_w < wt && g_w < wt && b_w < wt) begin
            o_class = CLASS_WHITE;
        end else if (r_w < g_w && r_w < b_w) begin
            o_class = CLASS_RED;
        end else if (g_w < r_w && g_w < b_w) begin
            o_class = CLASS_GREEN;
        end else if (b_w < r_w && b_w < g_w) begin
            o_class = CLASS_BLUE;
        end else begin
            o_class = CLASS_NONE;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rcmc_vote.sv]
// Vote counters, run position and end of run decision.
`default_nettype none

module rcmc_vote #(
    parameter int IDX_W = 4
) (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    input  var logic                              i_valid,
    input  var logic [rcmc_pkg::CLASS_W-1:0]      i_class,
    input  var logic [IDX_W-1:0]                  i_run_len,
    input  var logic [rcmc_pkg::CNT_CFG_W-1:0]    i_votes_needed,
    output var rcmc_pkg::t_decision               o_decision
);
    import rcmc_pkg::*;

    logic [VOTE_W-1:0] r_cnt [NUM_VOTES];
    logic [VOTE_W-1:0] n_cnt [NUM_VOTES];
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W:0]    idx_inc;
    logic              run_done;

    always_comb begin
        for (int k = 0; k < NUM_VOTES; k++) begin
            if (i_class == CLASS_W'(k + 1) && r_cnt[k] < VOTE_MAX) begin
                n_cnt[k] = r_cnt[k] + VOTE_W'(1);
            end else begin
                n_cnt[k] = r_cnt[k];
            end
        end
    end

    assign idx_inc  = {1'b0, r_idx} + (IDX_W + 1)'(1);
    assign run_done = idx_inc >= {1'b0, i_run_len};

    always_comb begin
        o_decision.ready = run_done;
        if (!run_done) begin
            o_decision.color = CLASS_NONE;
        end else if (n_cnt[0] >= i_votes_needed) begin
            o_decision.color = CLASS_RED;
        end else if (n_cnt[1] >= i_votes_needed) begin
            o_decision.color = CLASS_GREEN;
        end else if (n_cnt[2] >= i_votes_needed) begin
            o_decision.color = CLASS_BLUE;
        end else if (n_cnt[3] >= i_votes_needed) begin
            o_decision.color = CLASS_WHITE;
        end else begin
            o_decision.color = CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int k = 0; k < NUM_VOTES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_valid) begin
            if (run_done) begin
                r_idx <= '0;
                for (int k = 0; k < NUM_VOTES; k++) begin
                    r_cnt[k] <= '0;
                end
            end else begin
                r_idx <= idx_inc[IDX_W-1:0];
                for (int k = 0; k < NUM_VOTES; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/rgb_color_majority_classifier_top.sv]
// Top level of the RGB color majority classifier with input, output and configuration registers.
`default_nettype none

// Each input beat carries red, green and blue pulse widths and yields exactly one output
// beat with the sample class, and at the end of each voting run the decided color. One
// beat is taken every clock cycle while o_in_stall is low; an accepted beat waits in the
// input register and moves to the output register once that register is empty or its
// beat is being taken, and it stays offered there until the output side takes it.
// The classification and the vote update lie between the two registers. The user must
// write configuration through the plain write port only while no beat is in flight; the
// block itself does not enforce this. Writes to an index above three are ignored.
module rgb_color_majority_classifier_top #(
    parameter int WIDTH_BITS  = rcmc_pkg::WIDTH_BITS_DEF,
    parameter int MAX_SAMPLES = rcmc_pkg::MAX_SAMPLES_DEF
) (
    input  var logic                              i_clk,
    input  var logic                              i_rst_n,
    input  var logic                              i_in_valid,
    output var logic                              o_in_stall,
    input  var rcmc_pkg::t_in_beat                i_in_data,
    output var logic                              o_out_valid,
    input  var logic                              i_out_stall,
    output var rcmc_pkg::t_out_beat               o_out_data,
    input  var logic                              i_cfg_we,
    input  var logic [rcmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  var logic [rcmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rcmc_pkg::*;

    localparam int CMP_W   = (WIDTH_BITS < FIELD_W) ? WIDTH_BITS : FIELD_W;
    localparam int RUN_MAX = (MAX_SAMPLES < 15) ? MAX_SAMPLES : 15;
    localparam int IDX_W   = $clog2(RUN_MAX + 1);
    localparam logic [CNT_CFG_W-1:0] RUN_MAX_C = CNT_CFG_W'(RUN_MAX);

    logic [THR_W-1:0]     r_black_thr;
    logic [THR_W-1:0]     r_white_thr;
    logic [CNT_CFG_W-1:0] r_run_len;
    logic [CNT_CFG_W-1:0] r_votes_need;

    logic      r_in_vld;
    t_in_beat  r_in;
    logic      r_out_vld;
    t_out_beat r_out;
    t_out_beat n_out;

    logic                 advance;
    logic [CLASS_W-1:0]   sample_class;
    logic [CNT_CFG_W-1:0] run_len_eff;
    t_decision            decision;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_thr  <= BLACK_THR_RST;
            r_white_thr  <= WHITE_THR_RST;
            r_run_len    <= RUN_LEN_RST;
            r_votes_need <= VOTES_NEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLACK_THR:  r_black_thr  <= i_cfg_data[THR_W-1:0];
                CFG_WHITE_THR:  r_white_thr  <= i_cfg_data[THR_W-1:0];
                CFG_RUN_LEN:    r_run_len    <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_VOTES_NEED: r_votes_need <= i_cfg_data[CNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_run_len == '0) begin
            run_len_eff = CNT_CFG_W'(1);
        end else if (r_run_len > RUN_MAX_C) begin
            run_len_eff = RUN_MAX_C;
        end else begin
            run_len_eff = r_run_len;
        end
    end

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    rcmc_classify #(
        .CMP_W(CMP_W)
    ) u_classify (
        .i_beat      (r_in),
        .i_black_thr (r_black_thr),
        .i_white_thr (r_white_thr),
        .o_class     (sample_class)
    );

    rcmc_vote #(
        .IDX_W(IDX_W)
    ) u_vote (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (advance),
        .i_class        (sample_class),
        .i_run_len      (run_len_eff[IDX_W-1:0]),
        .i_votes_needed (r_votes_need),
        .o_decision     (decision)
    );

    always_comb begin
        n_out.sample_class   = sample_class;
        n_out.decision_ready = decision.ready;
        n_out.decided_color  = decision.color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_color_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.decision_ready) |-> (r_out.decided_color == CLASS_NONE))
        else $error("Decided color is set on a beat that does not end a run.");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.sample_class <= CLASS_BLACK))
        else $error("Sample class code is out of range.");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.decided_color <= CLASS_WHITE))
        else $error("Decided color code is out of range.");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_vld)
        else $error("An accepted beat was lost in the input register.");

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("An advanced beat did not reach the output register.");

endmodule

`default_nettype wire
